@@ sv/revolve_profile_vertices_core_macros.svh @@
// assertion helpers for the vertex ring generator
`ifndef REVOLVE_PROFILE_VERTICES_CORE_MACROS_SVH
`define REVOLVE_PROFILE_VERTICES_CORE_MACROS_SVH

// same-cycle implication, checked outside reset
`define RPV_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("rpv check failed");

// next-cycle implication, checked outside reset
`define RPV_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("rpv check failed");

`endif

@@ sv/rpv_pkg.sv @@
package rpv_pkg;

    // half-turn constant for the sine table
    localparam real PI = 3.14159265358979323846;

    // slice count after reset and its step values
    localparam logic [5:0]  RESET_SLICES   = 6'd16;
    localparam logic [16:0] FULL_PHASE     = 17'h10000;
    localparam logic [16:0] RESET_STEP_QUO = 17'(65536 / 16);
    localparam logic [5:0]  RESET_STEP_REM = 6'(65536 % 16);

    // register index decode (paddr[2])
    localparam logic REG_SLICE_COUNT = 1'b0;

    // rounding offset for q14 products
    localparam logic signed [31:0] ROUND_Q14 = 32'sd8192;

    // per-vertex bookkeeping carried down the pipeline
    typedef struct packed {
        logic [16:0] phase;
        logic [5:0]  slice;
        logic        last;
    } vtx_meta_t;

endpackage

@@ sv/revolve_profile_vertices_core.sv @@
// Ring generator for a surface of revolution. Each input word holds one profile point
// (radial, height, signed Q8.8); the block returns slice_count+1 vertex words for it,
// s = 0 .. slice_count, with position, slice tangent, texture u = floor(s*65536/slices),
// the slice index and tlast on the closing vertex. After the first vertex leaves the
// four-stage pipeline (phase step, synchronous dual-read sine ROM, multiply, round and
// saturate) one vertex follows each cycle unless the output stalls; the first vertex of a
// ring passes the generator registers and stages 1 to 3 before it is valid. The next word
// is taken in the cycle after the last vertex of the current ring has been issued into
// the pipeline. Writing slice_count starts a bit-serial division that computes the phase
// step; s_tready stays low until it ends. Output backpressure stalls the whole pipeline.
`include "revolve_profile_vertices_core_macros.svh"

module revolve_profile_vertices_core #(
    parameter int MAX_SLICES = 63,
    parameter int ANGLE_BITS = 12
) (
    input  logic         aclk,
    input  logic         aresetn,
    // input stream
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [31:0]  s_tdata,   // radial[15:0], height[31:16]
    // result stream
    output logic         m_tvalid,
    input  logic         m_tready,
    // pos_x[15:0], pos_y[31:16], pos_z[47:32], tangent_x[63:48], tangent_z[79:64],
    // tex_u[96:80], slice_index[102:97], zero pad[103]
    output logic [103:0] m_tdata,
    output logic         m_tlast,   // last_of_run
    // configuration
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    localparam int QTR         = 1 << (ANGLE_BITS - 2);
    localparam int ROM_AW      = ANGLE_BITS - 1;
    localparam int PHASE_SHIFT = 16 - ANGLE_BITS;
    // angle of one table step
    localparam real ANG_STEP   = rpv_pkg::PI / (2.0 * real'(QTR));

    typedef logic [14:0] sine_rom_t [QTR + 1];

    // quarter-wave sine table, built at elaboration
    function automatic sine_rom_t build_sine_rom();
        sine_rom_t rom;
        real       a;
        for (int j = 0; j <= QTR; j++) begin
            a = $sin(ANG_STEP * real'(j)) * 16384.0;
            rom[j] = 15'($rtoi($floor(a + 0.5)));
        end
        return rom;
    endfunction

    localparam sine_rom_t SINE_ROM = build_sine_rom();

    function automatic logic signed [15:0] sat16(input logic signed [18:0] v);
        logic signed [15:0] r;
        priority if (v > 19'sd32767) begin
            r = 16'sh7fff;
        end else if (v < -19'sd32768) begin
            r = -16'sh8000;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

    // configuration and step registers
    logic [5:0]  slices_reg;
    logic [16:0] step_quo_reg;
    logic [5:0]  step_rem_reg;

    // step divider
    logic        div_busy_reg;
    logic [4:0]  div_cnt_reg;
    logic [5:0]  div_rem_reg;
    logic [16:0] div_dvd_reg;
    logic [6:0]  div_trial;
    logic        div_qbit;
    logic [6:0]  div_rem_next;

    // ring generator
    logic        busy_reg;
    logic [5:0]  g_slice_reg;
    logic [16:0] g_phase_reg;
    logic [5:0]  g_rem_reg;
    logic [15:0] held_radial_reg;
    logic [15:0] held_height_reg;
    logic        g_last;
    logic [6:0]  g_rem_sum;

    // pipeline
    logic        adv;
    logic        v1_reg, v2_reg, m_valid_reg;
    rpv_pkg::vtx_meta_t meta1_reg, meta2_reg, meta3_reg;
    logic [15:0] rad1_reg, hgt1_reg, hgt2_reg, hgt3_reg;
    logic [14:0] sin_mag1_reg, cos_mag1_reg;
    logic        neg_s1_reg, neg_c1_reg;
    logic signed [31:0] px2_reg, pz2_reg;
    logic signed [15:0] tx2_reg, tz2_reg, tx3_reg, tz3_reg;
    logic signed [15:0] posx3_reg, posz3_reg;

    logic                     cfg_wr;
    logic [5:0]               cfg_clamped;
    logic [ANGLE_BITS-1:0]    ang_k;
    logic [1:0]               quad_s, quad_c;
    logic [ANGLE_BITS-3:0]    ang_j;
    logic [ROM_AW-1:0]        addr_s, addr_c;
    logic signed [15:0]       sn, cs;
    logic signed [31:0]       px_rnd, pz_rnd;
    logic signed [17:0]       rx, rz;

    // apb register access
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == rpv_pkg::REG_SLICE_COUNT);
    assign prdata = (paddr[2] == rpv_pkg::REG_SLICE_COUNT) ? 32'(slices_reg) : '0;

    // clamp the written slice count
    always_comb begin
        priority if (pwdata[5:0] == 6'd0) begin
            cfg_clamped = 6'd1;
        end else if (pwdata[5:0] > 6'(MAX_SLICES)) begin
            cfg_clamped = 6'(MAX_SLICES);
        end else begin
            cfg_clamped = pwdata[5:0];
        end
    end

    // restoring division 65536 / slices, one quotient bit a cycle
    assign div_trial    = {div_rem_reg, div_dvd_reg[16]};
    assign div_qbit     = (div_trial >= {1'b0, slices_reg});
    assign div_rem_next = div_qbit ? (div_trial - {1'b0, slices_reg}) : div_trial;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slices_reg   <= rpv_pkg::RESET_SLICES;
            step_quo_reg <= rpv_pkg::RESET_STEP_QUO;
            step_rem_reg <= rpv_pkg::RESET_STEP_REM;
            div_busy_reg <= 1'b0;
            div_cnt_reg  <= '0;
            div_rem_reg  <= '0;
            div_dvd_reg  <= '0;
        end else if (cfg_wr) begin
            slices_reg   <= cfg_clamped;
            div_busy_reg <= 1'b1;
            div_cnt_reg  <= '0;
            div_rem_reg  <= '0;
            div_dvd_reg  <= rpv_pkg::FULL_PHASE;
        end else if (div_busy_reg) begin
            div_rem_reg <= div_rem_next[5:0];
            div_dvd_reg <= {div_dvd_reg[15:0], div_qbit};
            div_cnt_reg <= div_cnt_reg + 5'd1;
            if (div_cnt_reg == 5'd16) begin
                step_quo_reg <= {div_dvd_reg[15:0], div_qbit};
                step_rem_reg <= div_rem_next[5:0];
                div_busy_reg <= 1'b0;
            end
        end
    end

    // ring generator: exact floor phase from quotient and remainder steps
    assign s_tready  = !busy_reg && !div_busy_reg;
    assign adv       = !m_valid_reg || m_tready;
    assign g_last    = (g_slice_reg == slices_reg);
    assign g_rem_sum = {1'b0, g_rem_reg} + {1'b0, step_rem_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg        <= 1'b0;
            g_slice_reg     <= '0;
            g_phase_reg     <= '0;
            g_rem_reg       <= '0;
            held_radial_reg <= '0;
            held_height_reg <= '0;
        end else if (s_tvalid && s_tready) begin
            busy_reg        <= 1'b1;
            g_slice_reg     <= '0;
            g_phase_reg     <= '0;
            g_rem_reg       <= '0;
            held_radial_reg <= s_tdata[15:0];
            held_height_reg <= s_tdata[31:16];
        end else if (busy_reg && adv) begin
            if (g_last) begin
                busy_reg <= 1'b0;
            end else begin
                g_slice_reg <= g_slice_reg + 6'd1;
                if (g_rem_sum >= {1'b0, slices_reg}) begin
                    g_rem_reg   <= 6'(g_rem_sum - {1'b0, slices_reg});
                    g_phase_reg <= g_phase_reg + step_quo_reg + 17'd1;
                end else begin
                    g_rem_reg   <= g_rem_sum[5:0];
                    g_phase_reg <= g_phase_reg + step_quo_reg;
                end
            end
        end
    end

    // angle index and quadrant folding for sine and cosine
    assign ang_k  = g_phase_reg[15:PHASE_SHIFT];
    assign quad_s = ang_k[ANGLE_BITS-1:ANGLE_BITS-2];
    assign quad_c = quad_s + 2'd1;
    assign ang_j  = ang_k[ANGLE_BITS-3:0];
    assign addr_s = quad_s[0] ? (ROM_AW'(QTR) - {1'b0, ang_j}) : {1'b0, ang_j};
    assign addr_c = quad_c[0] ? (ROM_AW'(QTR) - {1'b0, ang_j}) : {1'b0, ang_j};

    // stage 1: synchronous rom reads
    always_ff @(posedge aclk) begin
        if (adv) begin
            sin_mag1_reg <= SINE_ROM[addr_s];
            cos_mag1_reg <= SINE_ROM[addr_c];
            neg_s1_reg   <= quad_s[1];
            neg_c1_reg   <= quad_c[1];
            meta1_reg    <= '{phase: g_phase_reg, slice: g_slice_reg, last: g_last};
            rad1_reg     <= held_radial_reg;
            hgt1_reg     <= held_height_reg;
        end
    end

    // stage 2: signed sine and cosine, products
    assign sn = neg_s1_reg ? -$signed({1'b0, sin_mag1_reg}) : $signed({1'b0, sin_mag1_reg});
    assign cs = neg_c1_reg ? -$signed({1'b0, cos_mag1_reg}) : $signed({1'b0, cos_mag1_reg});

    always_ff @(posedge aclk) begin
        if (adv) begin
            px2_reg   <= $signed(rad1_reg) * cs;
            pz2_reg   <= $signed(rad1_reg) * sn;
            tx2_reg   <= -sn;
            tz2_reg   <= -cs;
            meta2_reg <= meta1_reg;
            hgt2_reg  <= hgt1_reg;
        end
    end

    // stage 3: round to q8.8 and saturate into the output register
    assign px_rnd = px2_reg + rpv_pkg::ROUND_Q14;
    assign pz_rnd = pz2_reg + rpv_pkg::ROUND_Q14;
    assign rx     = px_rnd[31:14];
    assign rz     = pz_rnd[31:14];

    always_ff @(posedge aclk) begin
        if (adv) begin
            posx3_reg <= sat16({rx[17], rx});
            posz3_reg <= sat16(-{rz[17], rz});
            tx3_reg   <= tx2_reg;
            tz3_reg   <= tz2_reg;
            meta3_reg <= meta2_reg;
            hgt3_reg  <= hgt2_reg;
        end
    end

    // pipeline valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            v1_reg      <= busy_reg;
            v2_reg      <= v1_reg;
            m_valid_reg <= v2_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tlast  = meta3_reg.last;
    assign m_tdata  = {1'b0, meta3_reg.slice, meta3_reg.phase, tz3_reg, tx3_reg,
                       posz3_reg, hgt3_reg, posx3_reg};

    // checks
    `RPV_ASSERT_NOW(a_close_phase, aclk, aresetn, m_tvalid && m_tlast, m_tdata[96:80] == rpv_pkg::FULL_PHASE)
    `RPV_ASSERT_NOW(a_close_index, aclk, aresetn, m_tvalid && m_tlast, m_tdata[102:97] == slices_reg)
    `RPV_ASSERT_NOW(a_open_phase, aclk, aresetn, m_tvalid && (m_tdata[102:97] == 6'd0), m_tdata[96:80] == 17'd0)
    `RPV_ASSERT_NEXT(a_ring_done, aclk, aresetn, busy_reg && g_last && adv, !busy_reg)

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps

module tb;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int HOLD_AT     = 600;
    localparam int HOLD_CYCLES = 400;
    localparam int MAX_SLICES  = 63;
    localparam int QTR_STEPS   = 1024;
    localparam int TURN_STEPS  = 4096;

    // register byte addresses
    localparam logic [2:0] ADDR_SLICE_COUNT = 3'd0;
    localparam logic [2:0] ADDR_UNMAPPED    = 3'd4;

    // one expected vertex, fields kept as raw bits
    typedef struct {
        logic [15:0] pos_x;
        logic [15:0] pos_y;
        logic [15:0] pos_z;
        logic [15:0] tan_x;
        logic [15:0] tan_z;
        logic [16:0] tex_u;
        logic [5:0]  slice;
        logic        last;
    } vertex_t;

    logic         aclk     = 1'b0;
    logic         aresetn  = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [31:0]  s_tdata  = '0;   // radial[15:0], height[31:16]
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    // pos_x, pos_y, pos_z, tangent_x, tangent_z, tex_u, slice_index, zero pad
    logic [103:0] m_tdata;
    logic         m_tlast;         // last_of_run
    logic         psel     = 1'b0;
    logic         penable  = 1'b0;
    logic         pwrite   = 1'b0;
    logic [2:0]   paddr    = '0;
    logic [31:0]  pwdata   = '0;
    logic [31:0]  prdata;
    logic         pready;

    int          sine_tbl [0:QTR_STEPS];
    int          ring_slices = 16;
    logic [31:0] profile_pend [$];
    vertex_t     vertex_expect [$];
    vertex_t     seen_exp;
    int          mismatch_count = 0;
    int          vertices_seen  = 0;
    int          send_gap, recv_gap, hold_left;
    bit          hold_done   = 1'b0;
    bit          steady_send = 1'b0;
    bit          steady_recv = 1'b0;
    int          cycle_count = 0;
    int          random_items;

    revolve_profile_vertices_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #6 aclk = ~aclk;

    // sine over a full turn from the quarter-wave table
    function automatic int sine_at(input int k);
        int q;
        int j;
        k = k & (TURN_STEPS - 1);
        q = k / QTR_STEPS;
        j = k % QTR_STEPS;
        case (q)
            0: begin
                return sine_tbl[j];
            end
            1: begin
                return sine_tbl[QTR_STEPS - j];
            end
            2: begin
                return -sine_tbl[j];
            end
            default: begin
                return -sine_tbl[QTR_STEPS - j];
            end
        endcase
    endfunction

    // q14 product rounded to q8.8, optionally negated, clamped to 16 bits
    function automatic logic [15:0] round_sat(input longint p, input bit negate);
        longint v;
        v = (p + 8192) >>> 14;
        if (negate) begin
            v = -v;
        end
        if (v > 32767) begin
            v = 32767;
        end else if (v < -32768) begin
            v = -32768;
        end
        return v[15:0];
    endfunction

    // expected ring of vertices for one profile word
    function automatic void predict_ring(input logic [31:0] word);
        vertex_t v;
        longint  r;
        longint  sn;
        longint  cs;
        longint  phase;
        int      k;
        r = longint'($signed(word[15:0]));
        for (int s = 0; s <= ring_slices; s++) begin
            phase   = (longint'(s) * 65536) / ring_slices;
            k       = int'(phase >> 4);
            sn      = sine_at(k);
            cs      = sine_at(k + QTR_STEPS);
            v.pos_x = round_sat(r * cs, 1'b0);
            v.pos_y = word[31:16];
            v.pos_z = round_sat(r * sn, 1'b1);
            v.tan_x = 16'(-sn);
            v.tan_z = 16'(-cs);
            v.tex_u = 17'(phase);
            v.slice = 6'(s);
            v.last  = (s == ring_slices);
            vertex_expect.insert(vertex_expect.size(), v);
        end
    endfunction

    task automatic check_field(input string name, input longint exp_v, input longint act_v);
        if (exp_v != act_v) begin
            $display("%0t ns: vertex %0d %s expected %0d, got %0d",
                     $time, vertices_seen, name, exp_v, act_v);
            mismatch_count++;
        end
    endtask

    // input driver: offers queued profile words, predicts on acceptance
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            send_gap = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                predict_ring(s_tdata);
                send_gap = steady_send ? 0 : $urandom_range(0, 9);
            end
            if (!s_tvalid || s_tready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_tvalid <= 1'b0;
                end else if (profile_pend.size() != 0) begin
                    s_tdata  <= profile_pend.pop_front();
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // result monitor: checks each vertex word, paces m_tready
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            recv_gap  = 0;
            hold_left = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (vertex_expect.size() == 0) begin
                    $display("%0t ns: vertex %0d expected none, got %h", $time,
                             vertices_seen, m_tdata);
                    mismatch_count++;
                end else begin
                    seen_exp = vertex_expect.pop_front();
                    check_field("pos_x", $signed(seen_exp.pos_x), $signed(m_tdata[15:0]));
                    check_field("pos_y", $signed(seen_exp.pos_y), $signed(m_tdata[31:16]));
                    check_field("pos_z", $signed(seen_exp.pos_z), $signed(m_tdata[47:32]));
                    check_field("tangent_x", $signed(seen_exp.tan_x), $signed(m_tdata[63:48]));
                    check_field("tangent_z", $signed(seen_exp.tan_z), $signed(m_tdata[79:64]));
                    check_field("tex_u", seen_exp.tex_u, m_tdata[96:80]);
                    check_field("slice_index", seen_exp.slice, m_tdata[102:97]);
                    check_field("pad", 0, m_tdata[103]);
                    check_field("last_of_run", seen_exp.last, m_tlast);
                end
                vertices_seen++;
                recv_gap = steady_recv ? 0 : $urandom_range(0, 9);
            end
            // one long hold-off while words are still queued, so the input backs up
            if (hold_left == 0 && !hold_done && vertices_seen >= HOLD_AT &&
                profile_pend.size() != 0) begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (recv_gap > 0) begin
                recv_gap--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // register write: setup then access cycle
    task automatic cfg_write(input logic [2:0] addr, input logic [31:0] val);
        int eff;
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == ADDR_SLICE_COUNT) begin
            eff = int'(val[5:0]);
            if (eff == 0) begin
                eff = 1;
            end
            if (eff > MAX_SLICES) begin
                eff = MAX_SLICES;
            end
            ring_slices = eff;
        end
        @(negedge aclk);
    endtask

    task automatic push_item(input logic [15:0] radial, input logic [15:0] height);
        profile_pend.insert(profile_pend.size(), {height, radial});
    endtask

    // wait until every queued word is in and every vertex is out
    task automatic drain();
        do begin
            @(negedge aclk);
        end while (profile_pend.size() != 0 || s_tvalid || vertex_expect.size() != 0);
        repeat (10) @(negedge aclk);
    endtask

    initial begin
        int          val;
        int          n;
        logic [15:0] rad;
        for (int j = 0; j <= QTR_STEPS; j++) begin
            sine_tbl[j] = int'($floor(16384.0 * $sin(rpv_pkg::PI / 2.0 * real'(j) /
                                                     real'(QTR_STEPS)) + 0.5));
        end
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // reset slice count: extremes, and saturation at quarter and half turn
        push_item(16'h0000, 16'h0000);
        push_item(16'h7FFF, 16'h7FFF);
        push_item(16'h8000, 16'h8000);
        push_item(16'h8000, 16'h1234);
        push_item(16'h7FFF, 16'hFFFF);
        push_item(16'hFFFF, 16'h0001);
        push_item(16'h0001, 16'h8000);
        push_item(16'h00FF, 16'h7F00);
        drain();

        // single slice
        cfg_write(ADDR_SLICE_COUNT, 32'd1);
        push_item(16'h8000, 16'h7FFF);
        push_item(16'h3039, 16'hEF1F);
        drain();

        // zero is taken as one slice
        cfg_write(ADDR_SLICE_COUNT, 32'd0);
        push_item(16'h7FFF, 16'h0000);
        drain();

        // largest ring
        cfg_write(ADDR_SLICE_COUNT, 32'd63);
        push_item(16'h8000, 16'h0064);
        push_item(16'h5555, 16'hAAAA);
        drain();

        // write to an unmapped register leaves the slice count alone
        cfg_write(ADDR_UNMAPPED, 32'd5);
        push_item(16'h8000, 16'hC000);
        drain();

        // upper data bits are dropped
        cfg_write(ADDR_SLICE_COUNT, 32'hFFFF_FFC3);
        push_item(16'h8000, 16'h0007);
        push_item(16'h7FFF, 16'hFFF9);
        drain();

        // two slices: half turn on the second vertex
        cfg_write(ADDR_SLICE_COUNT, 32'd2);
        push_item(16'h8000, 16'h0000);
        push_item(16'h8001, 16'h4000);
        drain();

        // random phases, mostly small rings
        random_items = 0;
        while (random_items < 280) begin
            n = $urandom_range(0, 7);
            if (n == 0) begin
                val = $urandom_range(32, 63);
            end else if (n == 1) begin
                val = 0;
            end else begin
                val = $urandom_range(1, 12);
            end
            cfg_write(ADDR_SLICE_COUNT, ($urandom() & 32'hFFFF_FFC0) | 32'(val));
            steady_send = ($urandom_range(0, 3) == 0);
            steady_recv = ($urandom_range(0, 3) == 0);
            n = (val >= 32) ? $urandom_range(3, 8) : $urandom_range(20, 40);
            for (int i = 0; i < n; i++) begin
                case ($urandom_range(0, 9))
                    0: begin
                        rad = 16'h8000;
                    end
                    1: begin
                        rad = 16'h7FFF;
                    end
                    2: begin
                        rad = ($urandom_range(0, 1) == 0) ? 16'h0000 : 16'hFFFF;
                    end
                    default: begin
                        rad = 16'($urandom());
                    end
                endcase
                push_item(rad, 16'($urandom()));
            end
            random_items += n;
            drain();
        end

        if (mismatch_count == 0 && vertex_expect.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
